// ===== src/rcsfx_pkg.sv =====
// Shared constants, types and functions for the RCS aspect feature extractor.
package rcsfx_pkg;

  localparam int MaxSamples = 256;
  localparam int AddrW = $clog2(MaxSamples);
  localparam int CountW = $clog2(MaxSamples + 1);

  localparam int AzW = 17;
  localparam int ElW = 15;
  localparam int RcsW = 15;

  localparam logic [AzW-1:0] AzLoRst = {1'b0, {(AzW-1){1'b1}}};
  localparam logic [AzW-1:0] AzHiRst = {1'b1, {(AzW-1){1'b0}}};
  localparam logic [ElW-1:0] ElLoRst = {1'b0, {(ElW-1){1'b1}}};
  localparam logic [ElW-1:0] ElHiRst = {1'b1, {(ElW-1){1'b0}}};

  localparam int AngleTol = 100;
  localparam int StdFull = 30000;
  localparam int SnrFull = 3000;
  localparam int CovFull = 6000;
  localparam int HalfQ = 2048;

  // Reciprocal of 3000 in Q35; the quotient is exact for dividends below 2^23.
  localparam logic [23:0] RecipQ35 = 24'd11453247;

  localparam logic CfgMinCoverage = 1'b0;
  localparam logic CfgMinSnr = 1'b1;

  // Distance word: sum of the squares of an 18-bit and a 16-bit difference.
  localparam int DistW = 38;

  typedef struct packed {
    logic signed [AzW-1:0] az;
    logic signed [ElW-1:0] el;
    logic signed [RcsW-1:0] rcs;
  } sample_t;

  typedef struct packed {
    logic start;
    logic [CountW-1:0] count;
    logic signed [AzW-1:0] look_az;
    logic signed [ElW-1:0] look_el;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic near_ok;
    logic signed [RcsW-1:0] mean;
  } scan_rsp_t;

  function automatic logic [23:0] step_q24(input logic [3:0] k);
    logic [23:0] v;
    case (k)
      4'd0: v = 24'd16757912;
      4'd1: v = 24'd16738629;
      4'd2: v = 24'd16700132;
      4'd3: v = 24'd16623401;
      4'd4: v = 24'd16470997;
      4'd5: v = 24'd16170368;
      4'd6: v = 24'd15585470;
      4'd7: v = 24'd14478377;
      4'd8: v = 24'd12494529;
      4'd9: v = 24'd9305075;
      4'd10: v = 24'd5160834;
      4'd11: v = 24'd1587522;
      4'd12: v = 24'd150217;
      4'd13: v = 24'd1345;
      default: v = 24'd16777215;
    endcase
    return v;
  endfunction

endpackage

// ===== src/rcsfx_store.sv =====
// Sample memory with write port and registered read port.
module rcsfx_store
  import rcsfx_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  sample_t          wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output sample_t          rd_data
);

  sample_t mem [MaxSamples];
  sample_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/rcsfx_scan.sv =====
// Nearest-sample search over the memory, one sample per cycle, pipelined.
module rcsfx_scan
  import rcsfx_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  scan_req_t        req,
  output logic [AddrW-1:0] rd_addr,
  input  sample_t          rd_data,
  output scan_rsp_t        rsp
);

  logic             run_r, run_nxt;
  logic [CountW-1:0] idx_r, idx_nxt;
  logic [CountW-1:0] cnt_r;
  logic signed [AzW-1:0] la_r;
  logic signed [ElW-1:0] le_r;
  logic             v1_r, v2_r, v3_r;
  logic             f1_r, f2_r, f3_r;
  logic             l1_r, l2_r, l3_r;
  logic signed [AzW:0] da_r;
  logic signed [ElW:0] de_r;
  logic signed [RcsW-1:0] rcs2_r, rcs3_r;
  logic [2*AzW+1:0] sa_r;
  logic [2*ElW+1:0] se_r;
  logic [DistW-1:0] dist_w;
  logic [DistW-1:0] best_r;
  logic signed [RcsW-1:0] mean_r;
  logic             done_r;
  logic             near_r;
  logic             single_r;

  function automatic logic da_r_abs_ok(input sample_t s, input logic signed [AzW-1:0] la,
                                       input logic signed [ElW-1:0] le);
    logic signed [AzW:0] a;
    logic signed [ElW:0] e;
    a = {s.az[AzW-1], s.az} - {la[AzW-1], la};
    e = {s.el[ElW-1], s.el} - {le[ElW-1], le};
    return (a <= (AzW+1)'(AngleTol)) && (a >= -(AzW+1)'(AngleTol))
        && (e <= (ElW+1)'(AngleTol)) && (e >= -(ElW+1)'(AngleTol));
  endfunction

  assign rd_addr = idx_r[AddrW-1:0];

  always_comb begin
    run_nxt = run_r;
    idx_nxt = idx_r;
    if (req.start) begin
      run_nxt = 1'b1;
      idx_nxt = '0;
    end else if (run_r) begin
      idx_nxt = idx_r + 1'b1;
      if (idx_r == cnt_r - 1'b1) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      v1_r <= run_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      done_r <= v3_r && l3_r;
    end
  end

  assign dist_w = {2'd0, sa_r} + {6'd0, se_r};

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (req.start) begin
      cnt_r <= req.count;
      la_r <= req.look_az;
      le_r <= req.look_el;
      single_r <= (req.count == CountW'(1));
    end
    f1_r <= (idx_r == '0);
    l1_r <= (idx_r == cnt_r - 1'b1);
    da_r <= {rd_data.az[AzW-1], rd_data.az} - {la_r[AzW-1], la_r};
    de_r <= {rd_data.el[ElW-1], rd_data.el} - {le_r[ElW-1], le_r};
    rcs2_r <= rd_data.rcs;
    f2_r <= f1_r;
    l2_r <= l1_r;
    sa_r <= $unsigned((2*AzW+2)'(da_r) * (2*AzW+2)'(da_r));
    se_r <= $unsigned((2*ElW+2)'(de_r) * (2*ElW+2)'(de_r));
    rcs3_r <= rcs2_r;
    f3_r <= f2_r;
    l3_r <= l2_r;
    if (v1_r && f1_r) begin
      near_r <= (da_r_abs_ok(rd_data, la_r, le_r));
    end
    if (v3_r && (f3_r || dist_w < best_r)) begin
      best_r <= dist_w;
      mean_r <= rcs3_r;
    end
  end

  assign rsp.done = done_r;
  assign rsp.near_ok = near_r || !single_r;
  assign rsp.mean = mean_r;

endmodule

// ===== src/rcsfx_std.sv =====
// Uncertainty from SNR: one Q24 scaling step per cycle.
module rcsfx_std
  import rcsfx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [13:0] snr,
  output logic        done,
  output logic [14:0] std_dev
);

  logic        run_r;
  logic [3:0]  k_r;
  logic [13:0] s_r;
  logic [24:0] p_r, p_nxt;
  logic [48:0] prod;
  logic [39:0] fin;
  logic        fin_r;
  logic [14:0] std_r;

  assign prod = p_r * step_q24(k_r) + 49'd8388608;
  assign fin = 40'(StdFull) * 40'(p_r) + 40'd8388608;

  always_comb begin
    p_nxt = p_r;
    if (s_r[k_r]) begin
      p_nxt = prod[48:24];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && k_r == 4'd13) begin
        run_r <= 1'b0;
        fin_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r <= '0;
      s_r <= snr;
      p_r <= 25'd16777216;
    end else if (run_r) begin
      k_r <= k_r + 1'b1;
      p_r <= p_nxt;
    end
    if (fin_r) begin
      std_r <= fin[38:24];
    end
  end

  logic done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
    end
  end

  assign done = done_r;
  assign std_dev = std_r;

endmodule

// ===== src/rcs_aspect_feature_extractor_core.sv =====
// Top level of the RCS aspect feature extractor.
//
//  channel | ports                               | flow
//  in      | start, busy, in_*                   | one word when start && !busy
//  out     | out_strobe, out_*                   | one word per evaluate, one cycle
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register write
//
// A store word leaves busy low. An evaluate puts its result on the outputs after
// the one-sample-per-cycle scan of the sample memory and the 14-step uncertainty
// calculation have both finished; busy is high meanwhile. Reset empties the store.
// The result strobe cannot be stalled.
module rcs_aspect_feature_extractor_core
  import rcsfx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_func,
  input  logic signed [16:0]    in_sample_az,
  input  logic signed [14:0]    in_sample_el,
  input  logic signed [14:0]    in_sample_rcs,
  input  logic signed [16:0]    in_look_az,
  input  logic signed [14:0]    in_look_el,
  input  logic signed [14:0]    in_snr,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data,
  output logic                  out_strobe,
  output logic                  out_valid_res,
  output logic signed [14:0]    out_mean_rcs,
  output logic [14:0]           out_std_dev,
  output logic [15:0]           out_coverage,
  output logic [14:0]           out_peak_to_valley,
  output logic [14:0]           out_az_variation,
  output logic [14:0]           out_el_variation,
  output logic [12:0]           out_quality,
  output logic                  out_overflowed
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StQual = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] st_r;
  logic [CountW-1:0] cnt_r;
  logic drop_r;
  logic signed [AzW-1:0] az_lo_r, az_hi_r;
  logic signed [ElW-1:0] el_lo_r, el_hi_r;
  logic signed [RcsW-1:0] rcs_lo_r, rcs_hi_r;
  logic [15:0] min_cov_r;
  logic [13:0] min_snr_r;
  logic signed [14:0] snr_r;
  logic scan_done_r, std_done_r;
  logic ok_r;
  logic signed [RcsW-1:0] mean_r;

  logic accept, store_en, eval_en;
  logic [AddrW-1:0] rd_addr;
  sample_t rd_data, wr_data;
  scan_req_t sreq;
  scan_rsp_t srsp;
  logic std_done;
  logic [14:0] std_val;

  logic [17:0] span_az;
  logic [15:0] span_el;
  logic [17:0] cov_w;
  logic [15:0] cov;
  logic [15:0] ptv_w;
  logic [14:0] ptv;
  logic [11:0] s_cl;
  logic [12:0] c_cl;
  logic [23:0] qs_num, qc_num;
  logic [47:0] qs_prod, qc_prod;
  logic [11:0] qs, qc;
  logic [12:0] q_r;
  logic qual_ok;

  assign accept = start && !busy;
  assign store_en = accept && !in_func && (cnt_r != CountW'(MaxSamples));
  assign eval_en = accept && in_func;
  assign busy = (st_r != StIdle);
  assign cfg_ready = 1'b1;

  assign wr_data.az = in_sample_az;
  assign wr_data.el = in_sample_el;
  assign wr_data.rcs = in_sample_rcs;

  rcsfx_store u_store (
    .clk(clk), .wr_en(store_en), .wr_addr(cnt_r[AddrW-1:0]), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign sreq.start = eval_en && (cnt_r != '0);
  assign sreq.count = cnt_r;
  assign sreq.look_az = in_look_az;
  assign sreq.look_el = in_look_el;

  rcsfx_scan u_scan (
    .clk(clk), .rst_n(rst_n), .req(sreq), .rd_addr(rd_addr), .rd_data(rd_data),
    .rsp(srsp)
  );

  rcsfx_std u_std (
    .clk(clk), .rst_n(rst_n), .start(eval_en), .snr(in_snr[13:0]),
    .done(std_done), .std_dev(std_val)
  );

  assign span_az = {az_hi_r[AzW-1], az_hi_r} - {az_lo_r[AzW-1], az_lo_r};
  assign span_el = {el_hi_r[ElW-1], el_hi_r} - {el_lo_r[ElW-1], el_lo_r};
  assign cov_w = (span_az < {2'd0, span_el}) ? span_az : {2'd0, span_el};
  assign cov = cov_w[15:0];
  assign ptv_w = {rcs_hi_r[RcsW-1], rcs_hi_r} - {rcs_lo_r[RcsW-1], rcs_lo_r};
  assign ptv = ptv_w[15] ? 15'h7FFF : ptv_w[14:0];

  // Both quotients divide by 3000 through the reciprocal; the coverage term
  // halves its even numerator first, which turns the 6000 into 3000.
  assign s_cl = (snr_r > 15'sd3000) ? 12'(SnrFull) : snr_r[11:0];
  assign c_cl = (cov > 16'(CovFull)) ? 13'(CovFull) : cov[12:0];
  assign qs_num = 24'(HalfQ) * 24'(s_cl) + 24'(SnrFull / 2);
  assign qc_num = 24'(HalfQ) * 24'(c_cl) + 24'(CovFull / 2);
  assign qs_prod = 48'(qs_num) * 48'(RecipQ35);
  assign qc_prod = 48'(qc_num[23:1]) * 48'(RecipQ35);
  assign qs = qs_prod[46:35];
  assign qc = qc_prod[46:35];
  assign qual_ok = ok_r && srsp.near_ok
                && ((cnt_r < CountW'(2)) || (cov >= min_cov_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle;
      cnt_r <= '0;
      drop_r <= 1'b0;
      az_lo_r <= AzLoRst; az_hi_r <= AzHiRst;
      el_lo_r <= ElLoRst; el_hi_r <= ElHiRst;
      rcs_lo_r <= ElLoRst; rcs_hi_r <= ElHiRst;
      min_cov_r <= '0;
      min_snr_r <= 14'd600;
      out_strobe <= 1'b0;
      scan_done_r <= 1'b0;
      std_done_r <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          CfgMinCoverage: min_cov_r <= cfg_data;
          CfgMinSnr:      min_snr_r <= cfg_data[13:0];
          default: ;
        endcase
      end
      if (accept && !in_func) begin
        if (store_en) begin
          cnt_r <= cnt_r + 1'b1;
          if (in_sample_az < az_lo_r) az_lo_r <= in_sample_az;
          if (in_sample_az > az_hi_r) az_hi_r <= in_sample_az;
          if (in_sample_el < el_lo_r) el_lo_r <= in_sample_el;
          if (in_sample_el > el_hi_r) el_hi_r <= in_sample_el;
          if (in_sample_rcs < rcs_lo_r) rcs_lo_r <= in_sample_rcs;
          if (in_sample_rcs > rcs_hi_r) rcs_hi_r <= in_sample_rcs;
        end else begin
          drop_r <= 1'b1;
        end
      end
      unique case (st_r)
        StIdle: begin
          if (eval_en) begin
            st_r <= StScan;
            scan_done_r <= (cnt_r == '0);
            std_done_r <= 1'b0;
          end
        end
        StScan: begin
          if (srsp.done) scan_done_r <= 1'b1;
          if (std_done) std_done_r <= 1'b1;
          if (scan_done_r && std_done_r) st_r <= StQual;
        end
        StQual: begin
          st_r <= StOut;
        end
        StOut: begin
          st_r <= StIdle;
          out_strobe <= 1'b1;
          cnt_r <= '0;
          drop_r <= 1'b0;
          az_lo_r <= AzLoRst; az_hi_r <= AzHiRst;
          el_lo_r <= ElLoRst; el_hi_r <= ElHiRst;
          rcs_lo_r <= ElLoRst; rcs_hi_r <= ElHiRst;
        end
        default: st_r <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (eval_en) begin
      snr_r <= in_snr;
      ok_r <= (cnt_r != '0) && !in_snr[14] && (in_snr[13:0] >= min_snr_r);
    end
    if (st_r == StQual) begin
      q_r <= 13'(qs) + 13'(qc);
      mean_r <= srsp.mean;
      ok_r <= qual_ok;
    end
    if (st_r == StOut) begin
      out_valid_res <= ok_r;
      out_mean_rcs <= ok_r ? mean_r : '0;
      out_std_dev <= ok_r ? std_val : '0;
      out_coverage <= (ok_r && cnt_r >= CountW'(2)) ? cov : '0;
      out_peak_to_valley <= ok_r ? ptv : '0;
      out_az_variation <= (ok_r && az_hi_r > az_lo_r) ? ptv : '0;
      out_el_variation <= (ok_r && el_hi_r > el_lo_r) ? ptv : '0;
      out_quality <= ok_r ? q_r : '0;
      out_overflowed <= drop_r;
    end
  end

endmodule

// ===== tb/rcsfx_tb_pkg.sv =====
// Operation codes shared by the feature extractor testbench files.
package rcsfx_tb_pkg;

  localparam logic FuncStore = 1'b0;
  localparam logic FuncEval = 1'b1;

endpackage

// ===== tb/rcsfx_checker.sv =====
// Checker that predicts feature extractor observations and compares them with the DUT.
module rcsfx_checker
  import rcsfx_pkg::*;
  import rcsfx_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_func,
  input  logic signed [16:0] in_sample_az,
  input  logic signed [14:0] in_sample_el,
  input  logic signed [14:0] in_sample_rcs,
  input  logic signed [16:0] in_look_az,
  input  logic signed [14:0] in_look_el,
  input  logic signed [14:0] in_snr,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               out_strobe,
  input  logic               out_valid_res,
  input  logic signed [14:0] out_mean_rcs,
  input  logic [14:0]        out_std_dev,
  input  logic [15:0]        out_coverage,
  input  logic [14:0]        out_peak_to_valley,
  input  logic [14:0]        out_az_variation,
  input  logic [14:0]        out_el_variation,
  input  logic [12:0]        out_quality,
  input  logic               out_overflowed,
  output int                 fail_count,
  output int                 pending_obs
);

  typedef struct packed {
    logic              valid_res;
    logic signed [14:0] mean_rcs;
    logic [14:0]       std_dev;
    logic [15:0]       coverage;
    logic [14:0]       ptv;
    logic [14:0]       az_var;
    logic [14:0]       el_var;
    logic [12:0]       quality;
    logic              overflowed;
  } obs_t;

  localparam logic [23:0] AttenQ24 [14] = '{
    24'd16757912, 24'd16738629, 24'd16700132, 24'd16623401, 24'd16470997,
    24'd16170368, 24'd15585470, 24'd14478377, 24'd12494529, 24'd9305075,
    24'd5160834, 24'd1587522, 24'd150217, 24'd1345
  };

  logic signed [16:0] az_mem [MaxSamples];
  logic signed [14:0] el_mem [MaxSamples];
  logic signed [14:0] rcs_mem [MaxSamples];
  int n_stored;
  logic dropped;
  int az_min, az_max, el_min, el_max, rcs_min, rcs_max;
  int cov_floor, snr_floor;
  obs_t obs_q[$];

  function automatic logic [14:0] uncertainty(input logic [14:0] snr);
    longint unsigned p;
    p = 64'd1 << 24;
    for (int k = 0; k < 14; k++) begin
      if (snr[k]) p = (p * AttenQ24[k] + 64'd8388608) >> 24;
    end
    return 15'((64'd30000 * p + 64'd8388608) >> 24);
  endfunction

  function automatic void empty_store();
    n_stored = 0;
    dropped = 1'b0;
    az_min = 65535;
    az_max = -65536;
    el_min = 16383;
    el_max = -16384;
    rcs_min = 16383;
    rcs_max = -16384;
  endfunction

  function automatic obs_t evaluate(input int la, input int le, input int snr);
    obs_t o;
    bit ok;
    int mean, cov, ptv, s, c, da, de;
    longint sq_dist, best;
    o = '0;
    o.overflowed = dropped;
    ok = (n_stored != 0) && (snr >= snr_floor);
    mean = 0;
    cov = 0;
    if (ok && n_stored == 1) begin
      da = az_mem[0] - la;
      de = el_mem[0] - le;
      if (da < 0) da = -da;
      if (de < 0) de = -de;
      if (da > AngleTol || de > AngleTol) ok = 0;
      else mean = rcs_mem[0];
    end else if (ok) begin
      best = 0;
      for (int n = 0; n < n_stored; n++) begin
        sq_dist = longint'(az_mem[n] - la) * (az_mem[n] - la)
                + longint'(el_mem[n] - le) * (el_mem[n] - le);
        if (n == 0 || sq_dist < best) begin
          best = sq_dist;
          mean = rcs_mem[n];
        end
      end
    end
    if (ok) begin
      cov = (az_max - az_min) < (el_max - el_min) ? az_max - az_min : el_max - el_min;
      if (n_stored >= 2 && cov < cov_floor) ok = 0;
    end
    if (ok) begin
      ptv = rcs_max - rcs_min;
      if (ptv > 32767) ptv = 32767;
      s = snr > SnrFull ? SnrFull : snr;
      c = cov > CovFull ? CovFull : cov;
      o.valid_res = 1'b1;
      o.mean_rcs = 15'(mean);
      o.std_dev = uncertainty(15'(snr));
      o.coverage = 16'(cov);
      o.ptv = 15'(ptv);
      o.az_var = az_max > az_min ? 15'(ptv) : '0;
      o.el_var = el_max > el_min ? 15'(ptv) : '0;
      o.quality = 13'((HalfQ * s + SnrFull / 2) / SnrFull + (HalfQ * c + CovFull / 2) / CovFull);
    end
    empty_store();
    return o;
  endfunction

  always @(posedge clk) begin
    obs_t want, got;
    if (!rst_n) begin
      empty_store();
      cov_floor = 0;
      snr_floor = 600;
      obs_q.delete();
      fail_count = 0;
    end else begin
      if (out_strobe) begin
        got = '{out_valid_res, out_mean_rcs, out_std_dev, out_coverage, out_peak_to_valley,
                out_az_variation, out_el_variation, out_quality, out_overflowed};
        if (obs_q.size() == 0) begin
          $display("%0t: unexpected observation %p", $time, got);
          fail_count++;
        end else begin
          want = obs_q.pop_front();
          if (got != want) begin
            $display("%0t: observation mismatch expected %p actual %p", $time, want, got);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgMinCoverage) cov_floor = cfg_data;
        else snr_floor = cfg_data[13:0];
      end
      if (start && !busy) begin
        if (in_func == FuncStore) begin
          if (n_stored >= MaxSamples) begin
            dropped = 1'b1;
          end else begin
            az_mem[n_stored] = in_sample_az;
            el_mem[n_stored] = in_sample_el;
            rcs_mem[n_stored] = in_sample_rcs;
            n_stored++;
            if (in_sample_az < az_min) az_min = in_sample_az;
            if (in_sample_az > az_max) az_max = in_sample_az;
            if (in_sample_el < el_min) el_min = in_sample_el;
            if (in_sample_el > el_max) el_max = in_sample_el;
            if (in_sample_rcs < rcs_min) rcs_min = in_sample_rcs;
            if (in_sample_rcs > rcs_max) rcs_max = in_sample_rcs;
          end
        end else begin
          obs_q.push_back(evaluate(in_look_az, in_look_el, in_snr));
        end
      end
    end
    pending_obs = obs_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives words into the feature extractor and reports the verdict.
module tb_top;
  import rcsfx_pkg::*;
  import rcsfx_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_func = FuncStore;
  logic signed [16:0] in_sample_az = '0;
  logic signed [14:0] in_sample_el = '0;
  logic signed [14:0] in_sample_rcs = '0;
  logic signed [16:0] in_look_az = '0;
  logic signed [14:0] in_look_el = '0;
  logic signed [14:0] in_snr = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CfgMinCoverage;
  logic [15:0] cfg_data = '0;
  logic out_strobe, out_valid_res, out_overflowed;
  logic signed [14:0] out_mean_rcs;
  logic [14:0] out_std_dev, out_peak_to_valley, out_az_variation, out_el_variation;
  logic [15:0] out_coverage;
  logic [12:0] out_quality;
  int fail_count, pending_obs;
  int max_gap;

  always #5 clk = ~clk;

  rcs_aspect_feature_extractor_core u_top (.*);

  rcsfx_checker u_checker (.*);

  task automatic send_word(input logic func, input int az, input int el, input int rcs,
                           input int laz, input int lel, input int snr);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= func;
    in_sample_az <= 17'(az);
    in_sample_el <= 15'(el);
    in_sample_rcs <= 15'(rcs);
    in_look_az <= 17'(laz);
    in_look_el <= 15'(lel);
    in_snr <= 15'(snr);
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(input logic idx, input int value);
    start <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_obs != 0);
    repeat (300) @(posedge clk);
  endtask

  function automatic int near(input int c, input int lim);
    int v;
    v = c + $urandom_range(0, 240) - 120;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  task automatic store_random(input int laz, input int lel, input bit close);
    if (close)
      send_word(FuncStore, near(laz, 36000), near(lel, 9000), $urandom_range(0, 20000) - 10000,
                $urandom_range(0, 72000) - 36000, $urandom_range(0, 18000) - 9000,
                $urandom_range(0, 20000) - 10000);
    else
      send_word(FuncStore, $urandom_range(0, 72000) - 36000, $urandom_range(0, 18000) - 9000,
                $urandom_range(0, 20000) - 10000, laz, lel, $urandom_range(0, 20000) - 10000);
  endtask

  task automatic random_group(input bit fill, output int sent);
    int n, laz, lel, snr, roll;
    roll = $urandom_range(0, 99);
    if (fill) n = $urandom_range(257, 262);
    else if (roll < 8) n = 0;
    else if (roll < 80) n = $urandom_range(1, 6);
    else n = $urandom_range(7, 40);
    laz = $urandom_range(0, 72000) - 36000;
    lel = $urandom_range(0, 18000) - 9000;
    for (int i = 0; i < n; i++) store_random(laz, lel, $urandom_range(0, 9) < 8);
    snr = $urandom_range(0, 9) == 0 ? $urandom_range(0, 20000) - 10000 : $urandom_range(0, 10000);
    send_word(FuncEval, $urandom_range(0, 72000) - 36000, $urandom_range(0, 18000) - 9000,
              $urandom_range(0, 20000) - 10000, laz, lel, snr);
    sent = n + 1;
  endtask

  initial begin
    int items;
    int sent;
    max_gap = 8;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(FuncEval, 0, 0, 0, 0, 0, 3000);
    send_word(FuncStore, 36000, 9000, 10000, 0, 0, 0);
    send_word(FuncEval, 0, 0, 0, 36000, 9000, 10000);
    send_word(FuncStore, -36000, -9000, -10000, 0, 0, 0);
    send_word(FuncEval, 0, 0, 0, -35900, -8900, 10000);
    send_word(FuncStore, 100, -100, 55, 0, 0, 0);
    send_word(FuncEval, 0, 0, 0, 0, 0, 599);
    send_word(FuncStore, 100, -101, 55, 0, 0, 0);
    send_word(FuncEval, 0, 0, 0, 0, 0, 600);
    send_word(FuncStore, 0, 0, 12, 0, 0, 0);
    send_word(FuncEval, 0, 0, 0, 0, 0, -10000);
    send_word(FuncStore, -36000, -9000, -10000, 0, 0, 0);
    send_word(FuncStore, 36000, 9000, 10000, 0, 0, 0);
    send_word(FuncStore, 0, 0, 7, 0, 0, 0);
    send_word(FuncStore, 0, 0, 9, 0, 0, 0);
    send_word(FuncEval, 0, 0, 0, 0, 0, 10000);
    send_word(FuncStore, 500, 0, -3, 0, 0, 0);
    send_word(FuncStore, 500, 0, 4, 0, 0, 0);
    send_word(FuncEval, 0, 0, 0, 500, 0, 16383);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CfgMinCoverage, 0); write_reg(CfgMinSnr, 0); end
        1: begin write_reg(CfgMinCoverage, 36000); write_reg(CfgMinSnr, 10000); end
        2: begin write_reg(CfgMinCoverage, 65535); write_reg(CfgMinSnr, 16383); end
        default: begin
          write_reg(CfgMinCoverage, $urandom_range(0, 400));
          write_reg(CfgMinSnr, $urandom_range(0, 3000));
        end
      endcase
      max_gap = (ph == 3) ? 0 : 8;
      items = 0;
      while (items < (ph == 2 ? 20 : (ph == 4 ? 1 : 30))) begin
        random_group(ph == 4 && items == 0, sent);
        items += sent;
      end
      drain();
    end

    if (fail_count == 0) $display("** rcs_aspect_feature_extractor_core: PASSED **");
    else $display("** rcs_aspect_feature_extractor_core: FAILED **");
    $finish;
  end

  initial begin
    #5000000;
    $display("** rcs_aspect_feature_extractor_core: FAILED **");
    $finish;
  end

endmodule

// ===== rcs_aspect_feature_extractor_core.f =====
src/rcsfx_pkg.sv
src/rcsfx_store.sv
src/rcsfx_scan.sv
src/rcsfx_std.sv
src/rcs_aspect_feature_extractor_core.sv
tb/rcsfx_tb_pkg.sv
tb/rcsfx_checker.sv
tb/tb_top.sv
